// ===== sv/assert_macros.svh =====
// Assertion helpers shared by the RTL files. Each macro expects the module to
// have a clock named i_clk and a synchronous active-low reset named i_rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: whenever ante holds, cons must hold on that edge.
`define DDS_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication: whenever ante holds, cons must hold on the following edge.
`define DDS_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/dds_pkg.sv =====
package dds_pkg;

    localparam int unsigned PHASE_BITS_DEF      = 32;
    localparam int unsigned SINE_TABLE_BITS_DEF = 10;

    // pi/2 in Q30 and 1/(2*pi) in Q32.
    localparam logic [63:0] HALF_PI_Q30    = 64'd1686629713;
    localparam logic [29:0] INV_TWO_PI_Q32 = 30'd683565276;

    // Width of the AM multiplier m (Q27, signed).
    localparam int unsigned M_W = 33;
    localparam logic signed [33:0] AM_UNITY = 34'sd134217728;

    localparam logic signed [17:0] Q15_ONE = 18'sd32768;

    localparam logic signed [31:0] SAMPLE_MAX = 32'sd8388607;
    localparam logic signed [31:0] SAMPLE_MIN = -32'sd8388608;

    // Divider geometry for the FM deviation quotient.
    localparam int unsigned DIV_NUM_W   = 64;
    localparam int unsigned DIV_DEN_W   = 32;
    localparam int unsigned DIV_SB_W_DEF = PHASE_BITS_DEF + M_W + 1;

    // Register map, word index.
    localparam logic [2:0] REG_WAVE_SHAPE   = 3'd0;
    localparam logic [2:0] REG_MOD_MODE     = 3'd1;
    localparam logic [2:0] REG_CARRIER_STEP = 3'd2;
    localparam logic [2:0] REG_START_PHASE  = 3'd3;
    localparam logic [2:0] REG_MOD_STEP     = 3'd4;
    localparam logic [2:0] REG_MOD_DEPTH    = 3'd5;
    localparam logic [2:0] REG_GAIN         = 3'd6;
    localparam logic [2:0] REG_DC_OFFSET    = 3'd7;

    localparam logic [1:0] WAVE_SINE     = 2'd0;
    localparam logic [1:0] WAVE_SQUARE   = 2'd1;
    localparam logic [1:0] WAVE_TRIANGLE = 2'd2;
    localparam logic [1:0] WAVE_SAW      = 2'd3;

    localparam logic [1:0] MOD_NONE = 2'd0;
    localparam logic [1:0] MOD_AM   = 2'd1;
    localparam logic [1:0] MOD_FM   = 2'd2;

    // One quarter-wave sine entry, sin(k*pi/(2N)) in Q15, from a Q30 Taylor
    // series. Only evaluated at elaboration to fill the table.
    function automatic logic [15:0] f_sine_entry(input int unsigned k,
                                                 input int unsigned tbl_bits);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] v;
        longint      sum;
        int unsigned n;
        x    = (64'(k) * HALF_PI_Q30) >> tbl_bits;
        x2   = (x * x) >> 30;
        term = x;
        sum  = longint'(x);
        for (n = 1; n <= 12; n++) begin
            term = (term * x2) >> 30;
            term = term / 64'((2 * n) * (2 * n + 1));
            if (n[0]) begin
                sum = sum - longint'(term);
            end else begin
                sum = sum + longint'(term);
            end
        end
        if (sum < 0) begin
            sum = 0;
        end
        v = (64'(sum) * 64'd32768 + 64'd536870912) >> 30;
        if (v > 64'd32768) begin
            v = 64'd32768;
        end
        return v[15:0];
    endfunction

endpackage

// ===== sv/dds_waveform_generator_am_fm.sv =====
// Waveform synthesizer: one signed 24-bit sample per transaction.
// Input channel: drive i_sample_index and pulse start; the transaction is taken
// at a clock edge where start is high and busy is low. busy is always low, so a
// new sample index may be issued on every cycle.
// Output channel: o_valid marks o_sample and o_clipped for exactly one cycle.
// The receiver cannot stall; results appear in issue order, one per index.
// Pipeline: four front stages, a 64-stage FM divider that every transaction
// passes through, and nine back stages. Throughput is one sample per clock.
// Configuration: APB-style writes at byte address 4*index; pready is tied high.
// Registers should only be written while no transaction is in flight.
// Reset (synchronous, i_rst_n low) clears the pipeline valid bits and loads
// the register defaults (unit gain of 256, everything else zero).
// The sine comes from two copies of a quarter-wave ROM built at elaboration:
// one for the modulator, one for the carrier.
`include "assert_macros.svh"

module dds_waveform_generator_am_fm #(
    parameter int unsigned PHASE_BITS      = dds_pkg::PHASE_BITS_DEF,
    parameter int unsigned SINE_TABLE_BITS = dds_pkg::SINE_TABLE_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [31:0]        i_sample_index,
    output logic               o_valid,
    output logic signed [23:0] o_sample,
    output logic               o_clipped,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam int unsigned PB     = PHASE_BITS;
    localparam int unsigned STB    = SINE_TABLE_BITS;
    localparam int unsigned M_W    = dds_pkg::M_W;
    localparam int unsigned SB_W   = PB + M_W + 1;
    localparam int unsigned NUM_W  = dds_pkg::DIV_NUM_W;
    localparam int unsigned DEN_W  = dds_pkg::DIV_DEN_W;
    localparam int unsigned LAT    = 4 + NUM_W + 9;
    localparam logic [STB:0] TBL_N = {1'b1, {STB{1'b0}}};

    // Table address for a phase: quadrant bit 0 mirrors the index.
    function automatic logic [STB:0] f_tbl_addr(input logic quad_odd,
                                                input logic [STB-1:0] idx);
        return quad_odd ? (TBL_N - {1'b0, idx}) : {1'b0, idx};
    endfunction

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [1:0]         r_wave_shape;
    logic [1:0]         r_mod_mode;
    logic [31:0]        r_carrier_step;
    logic [31:0]        r_start_phase;
    logic [31:0]        r_mod_step;
    logic [15:0]        r_mod_depth;
    logic [15:0]        r_gain;
    logic signed [23:0] r_dc_offset;
    logic               n_cfg_wr;

    assign pready   = 1'b1;
    assign n_cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wave_shape   <= dds_pkg::WAVE_SINE;
            r_mod_mode     <= dds_pkg::MOD_NONE;
            r_carrier_step <= '0;
            r_start_phase  <= '0;
            r_mod_step     <= '0;
            r_mod_depth    <= '0;
            r_gain         <= 16'd256;
            r_dc_offset    <= '0;
        end else if (n_cfg_wr) begin
            unique case (paddr[4:2])
                dds_pkg::REG_WAVE_SHAPE:   r_wave_shape   <= pwdata[1:0];
                dds_pkg::REG_MOD_MODE:     r_mod_mode     <= pwdata[1:0];
                dds_pkg::REG_CARRIER_STEP: r_carrier_step <= pwdata;
                dds_pkg::REG_START_PHASE:  r_start_phase  <= pwdata;
                dds_pkg::REG_MOD_STEP:     r_mod_step     <= pwdata;
                dds_pkg::REG_MOD_DEPTH:    r_mod_depth    <= pwdata[15:0];
                dds_pkg::REG_GAIN:         r_gain         <= pwdata[15:0];
                dds_pkg::REG_DC_OFFSET:    r_dc_offset    <= $signed(pwdata[23:0]);
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[4:2])
            dds_pkg::REG_WAVE_SHAPE:   prdata = {30'd0, r_wave_shape};
            dds_pkg::REG_MOD_MODE:     prdata = {30'd0, r_mod_mode};
            dds_pkg::REG_CARRIER_STEP: prdata = r_carrier_step;
            dds_pkg::REG_START_PHASE:  prdata = r_start_phase;
            dds_pkg::REG_MOD_STEP:     prdata = r_mod_step;
            dds_pkg::REG_MOD_DEPTH:    prdata = {16'd0, r_mod_depth};
            dds_pkg::REG_GAIN:         prdata = {16'd0, r_gain};
            dds_pkg::REG_DC_OFFSET:    prdata = {8'd0, r_dc_offset};
            default:                   prdata = '0;
        endcase
    end

    // The pipeline never stalls, so the input side is always open.
    assign busy = 1'b0;

    // ------------------------------------------------------------------
    // Stage 1: phase multiplies, modulo 2^32, and the depth*carrier-step product.
    // ------------------------------------------------------------------
    logic        n_accept;
    logic        r_s1_v;
    logic [31:0] r_s1_pc;
    logic [31:0] r_s1_pm;
    logic [47:0] r_s1_dc;

    assign n_accept = start && !busy;

    always_ff @(posedge i_clk) begin
        r_s1_pc <= r_carrier_step * i_sample_index;
        r_s1_pm <= r_mod_step * i_sample_index;
        r_s1_dc <= 48'(r_mod_depth) * 48'(r_carrier_step);
    end

    // ------------------------------------------------------------------
    // Stage 2: add the start phase and align both phases to PB bits.
    // ------------------------------------------------------------------
    logic [31:0]    n_csum;
    logic [PB+31:0] n_cext;
    logic [PB+31:0] n_mext;
    logic           r_s2_v;
    logic [PB-1:0]  r_s2_cph;
    logic [PB-1:0]  r_s2_mph;
    logic [47:0]    r_s2_dc;

    assign n_csum = r_s1_pc + r_start_phase;
    assign n_cext = {n_csum, {PB{1'b0}}};
    assign n_mext = {r_s1_pm, {PB{1'b0}}};

    always_ff @(posedge i_clk) begin
        r_s2_cph <= n_cext[PB+31:32];
        r_s2_mph <= n_mext[PB+31:32];
        r_s2_dc  <= r_s1_dc;
    end

    // ------------------------------------------------------------------
    // Stage 3: modulator table read. AM reads the cosine, which is one
    // quadrant ahead of the sine.
    // ------------------------------------------------------------------
    logic [1:0]    n_mquad;
    logic [STB:0]  n_maddr;
    logic [15:0]   n_mtbl;
    logic          r_s3_v;
    logic [PB-1:0] r_s3_cph;
    logic          r_s3_mneg;
    logic [47:0]   r_s3_dc;

    assign n_mquad = r_s2_mph[PB-1:PB-2]
                   + ((r_mod_mode == dds_pkg::MOD_AM) ? 2'd1 : 2'd0);
    assign n_maddr = f_tbl_addr(n_mquad[0], r_s2_mph[PB-3 -: STB]);

    dds_sine_rom #(
        .TBL_BITS (STB)
    ) u_mod_rom (
        .i_clk  (i_clk),
        .i_addr (n_maddr),
        .o_data (n_mtbl)
    );

    always_ff @(posedge i_clk) begin
        r_s3_cph  <= r_s2_cph;
        r_s3_mneg <= n_mquad[1];
        r_s3_dc   <= r_s2_dc;
    end

    // ------------------------------------------------------------------
    // Stage 4: AM factor m in Q27 and the FM dividend depth*step*|s|.
    // ------------------------------------------------------------------
    logic signed [16:0] n_sv;
    logic signed [33:0] n_am_prod;
    logic signed [33:0] n_m;
    logic               r_s4_v;
    logic [NUM_W-1:0]   r_s4_num;
    logic [SB_W-1:0]    r_s4_sb;

    assign n_sv      = r_s3_mneg ? -$signed({1'b0, n_mtbl}) : $signed({1'b0, n_mtbl});
    assign n_am_prod = $signed({1'b0, r_mod_depth}) * n_sv;
    assign n_m       = (r_mod_mode == dds_pkg::MOD_AM) ? (n_am_prod + dds_pkg::AM_UNITY)
                                                       : dds_pkg::AM_UNITY;

    always_ff @(posedge i_clk) begin
        r_s4_num <= 64'(r_s3_dc) * 64'(n_mtbl);
        r_s4_sb  <= {r_s3_cph, n_m[M_W-1:0], r_s3_mneg && (n_mtbl != 16'd0)};
    end

    // ------------------------------------------------------------------
    // Divider: dividend over the modulator step (zero taken as one).
    // ------------------------------------------------------------------
    logic [DEN_W-1:0] n_den;
    logic             n_dv;
    logic [NUM_W-1:0] n_quot;
    logic [SB_W-1:0]  n_dsb;

    assign n_den = (r_mod_step == '0) ? DEN_W'(1) : r_mod_step;

    dds_div_pipe #(
        .NUM_W (NUM_W),
        .DEN_W (DEN_W),
        .SB_W  (SB_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_s4_v),
        .i_num   (r_s4_num),
        .i_den   (n_den),
        .i_sb    (r_s4_sb),
        .o_valid (n_dv),
        .o_quot  (n_quot),
        .o_sb    (n_dsb)
    );

    // ------------------------------------------------------------------
    // Back stages: scale the quotient by 1/(2*pi), apply the deviation,
    // look up the carrier, shape it, scale, round, add the offset and saturate.
    // ------------------------------------------------------------------
    logic [60:0]           n_phi;
    logic [61:0]           n_plo;
    logic                  r_s5_v;
    logic [26:0]           r_s5_phi;
    logic [58:0]           r_s5_plo;
    logic [PB-1:0]         r_s5_cph;
    logic signed [M_W-1:0] r_s5_m;
    logic                  r_s5_fmneg;

    assign n_phi = 61'(n_quot[62:32]) * 61'(dds_pkg::INV_TWO_PI_Q32);
    assign n_plo = 62'(n_quot[31:0]) * 62'(dds_pkg::INV_TWO_PI_Q32);

    always_ff @(posedge i_clk) begin
        r_s5_phi   <= n_phi[26:0];
        r_s5_plo   <= n_plo[58:0];
        r_s5_cph   <= n_dsb[SB_W-1 -: PB];
        r_s5_m     <= $signed(n_dsb[M_W:1]);
        r_s5_fmneg <= n_dsb[0];
    end

    logic [58:0]           n_full;
    logic                  r_s6_v;
    logic [PB-1:0]         r_s6_off;
    logic [PB-1:0]         r_s6_cph;
    logic signed [M_W-1:0] r_s6_m;
    logic                  r_s6_fmneg;

    assign n_full = {r_s5_phi, 32'd0} + r_s5_plo;

    always_ff @(posedge i_clk) begin
        r_s6_off   <= n_full[58 -: PB];
        r_s6_cph   <= r_s5_cph;
        r_s6_m     <= r_s5_m;
        r_s6_fmneg <= r_s5_fmneg;
    end

    logic                  r_s7_v;
    logic [PB-1:0]         r_s7_cph;
    logic signed [M_W-1:0] r_s7_m;

    always_ff @(posedge i_clk) begin
        if (r_mod_mode == dds_pkg::MOD_FM) begin
            r_s7_cph <= r_s6_fmneg ? (r_s6_cph - r_s6_off) : (r_s6_cph + r_s6_off);
        end else begin
            r_s7_cph <= r_s6_cph;
        end
        r_s7_m <= r_s6_m;
    end

    logic [STB:0]          n_caddr;
    logic [15:0]           n_ctbl;
    logic                  r_s8_v;
    logic                  r_s8_qneg;
    logic [15:0]           r_s8_u;
    logic signed [M_W-1:0] r_s8_m;

    assign n_caddr = f_tbl_addr(r_s7_cph[PB-2], r_s7_cph[PB-3 -: STB]);

    dds_sine_rom #(
        .TBL_BITS (STB)
    ) u_car_rom (
        .i_clk  (i_clk),
        .i_addr (n_caddr),
        .o_data (n_ctbl)
    );

    always_ff @(posedge i_clk) begin
        r_s8_qneg <= r_s7_cph[PB-1];
        r_s8_u    <= r_s7_cph[PB-1 -: 16];
        r_s8_m    <= r_s7_m;
    end

    // Wave shape, Q15 in [-32768, 32768].
    logic signed [17:0] n_sin;
    logic signed [17:0] n_du;
    logic signed [17:0] n_adu;
    logic signed [17:0] n_w;
    logic               r_s9_v;
    logic [15:0]        r_s9_wmag;
    logic               r_s9_neg;
    logic [31:0]        r_s9_mmag;

    assign n_sin = r_s8_qneg ? -$signed({2'b0, n_ctbl}) : $signed({2'b0, n_ctbl});
    assign n_du  = $signed({2'b0, r_s8_u}) - dds_pkg::Q15_ONE;
    assign n_adu = (n_du < 0) ? -n_du : n_du;

    always_comb begin
        case (r_wave_shape)
            dds_pkg::WAVE_SQUARE: begin
                n_w = (n_sin >= 0) ? dds_pkg::Q15_ONE : -dds_pkg::Q15_ONE;
            end
            dds_pkg::WAVE_TRIANGLE: n_w = (n_adu <<< 1) - dds_pkg::Q15_ONE;
            dds_pkg::WAVE_SAW:      n_w = n_du;
            default:                n_w = n_sin;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_s9_wmag <= (n_w < 0) ? 16'(-n_w) : 16'(n_w);
        r_s9_neg  <= (n_w < 0) != (r_s8_m < 0);
        r_s9_mmag <= (r_s8_m < 0) ? 32'(-r_s8_m) : 32'(r_s8_m);
    end

    logic        r_s10_v;
    logic [31:0] r_s10_gw;
    logic [31:0] r_s10_mmag;
    logic        r_s10_neg;

    always_ff @(posedge i_clk) begin
        r_s10_gw   <= 32'(r_gain) * 32'(r_s9_wmag);
        r_s10_mmag <= r_s9_mmag;
        r_s10_neg  <= r_s9_neg;
    end

    logic        r_s11_v;
    logic [63:0] r_s11_mag;
    logic        r_s11_neg;

    always_ff @(posedge i_clk) begin
        r_s11_mag <= 64'(r_s10_gw) * 64'(r_s10_mmag);
        r_s11_neg <= r_s10_neg;
    end

    // Round half away from zero by rounding the magnitude.
    logic [64:0]        n_rnd;
    logic               r_s12_v;
    logic signed [31:0] r_s12_s;

    assign n_rnd = 65'(r_s11_mag) + (65'd1 << 34);

    always_ff @(posedge i_clk) begin
        r_s12_s <= r_s11_neg ? -$signed({2'b0, n_rnd[64:35]})
                             : $signed({2'b0, n_rnd[64:35]});
    end

    // Offset and saturation into the output register.
    logic signed [31:0] n_sum;
    logic               r_valid;
    logic signed [23:0] r_sample;
    logic               r_clipped;

    assign n_sum = r_s12_s + $signed({{8{r_dc_offset[23]}}, r_dc_offset});

    always_ff @(posedge i_clk) begin
        if (n_sum > dds_pkg::SAMPLE_MAX) begin
            r_sample <= dds_pkg::SAMPLE_MAX[23:0];
        end else if (n_sum < dds_pkg::SAMPLE_MIN) begin
            r_sample <= dds_pkg::SAMPLE_MIN[23:0];
        end else begin
            r_sample <= n_sum[23:0];
        end
    end

    // Valid bits, cleared by reset. The divider carries its own.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v    <= 1'b0;
            r_s2_v    <= 1'b0;
            r_s3_v    <= 1'b0;
            r_s4_v    <= 1'b0;
            r_s5_v    <= 1'b0;
            r_s6_v    <= 1'b0;
            r_s7_v    <= 1'b0;
            r_s8_v    <= 1'b0;
            r_s9_v    <= 1'b0;
            r_s10_v   <= 1'b0;
            r_s11_v   <= 1'b0;
            r_s12_v   <= 1'b0;
            r_valid   <= 1'b0;
            r_clipped <= 1'b0;
        end else begin
            r_s1_v    <= n_accept;
            r_s2_v    <= r_s1_v;
            r_s3_v    <= r_s2_v;
            r_s4_v    <= r_s3_v;
            r_s5_v    <= n_dv;
            r_s6_v    <= r_s5_v;
            r_s7_v    <= r_s6_v;
            r_s8_v    <= r_s7_v;
            r_s9_v    <= r_s8_v;
            r_s10_v   <= r_s9_v;
            r_s11_v   <= r_s10_v;
            r_s12_v   <= r_s11_v;
            r_valid   <= r_s12_v;
            r_clipped <= r_s12_v
                      && ((n_sum > dds_pkg::SAMPLE_MAX) || (n_sum < dds_pkg::SAMPLE_MIN));
        end
    end

    assign o_valid   = r_valid;
    assign o_sample  = r_sample;
    assign o_clipped = r_clipped;

    `DDS_ASSERT_NXT(a_accept_enters, n_accept, r_s1_v, "accepted transaction not in stage 1")
    `DDS_ASSERT_IMP(a_out_from_in, o_valid, $past(n_accept, LAT), "result without a transaction")
    `DDS_ASSERT_IMP(a_clip_sat, o_clipped, o_valid && ((o_sample == dds_pkg::SAMPLE_MAX[23:0]) || (o_sample == dds_pkg::SAMPLE_MIN[23:0])), "clip flag on unsaturated sample")

endmodule

// ===== sv/dds_sine_rom.sv =====
module dds_sine_rom #(
    parameter int unsigned TBL_BITS = dds_pkg::SINE_TABLE_BITS_DEF
) (
    input  logic                i_clk,
    input  logic [TBL_BITS:0]   i_addr,
    output logic [15:0]         o_data
);

    localparam int unsigned DEPTH = (1 << TBL_BITS) + 1;

    typedef logic [15:0] t_rom [0:DEPTH-1];

    function automatic t_rom f_build();
        t_rom tbl;
        int   k;
        for (k = 0; k < DEPTH; k++) begin
            tbl[k] = dds_pkg::f_sine_entry(k, TBL_BITS);
        end
        return tbl;
    endfunction

    localparam t_rom SINE_ROM = f_build();

    logic [15:0] r_data;

    always_ff @(posedge i_clk) begin
        r_data <= SINE_ROM[i_addr];
    end

    assign o_data = r_data;

endmodule

// ===== sv/dds_div_pipe.sv =====
`include "assert_macros.svh"

// Restoring divider, one quotient bit per stage, with a sideband that rides
// along with each transaction.
module dds_div_pipe #(
    parameter int unsigned NUM_W = dds_pkg::DIV_NUM_W,
    parameter int unsigned DEN_W = dds_pkg::DIV_DEN_W,
    parameter int unsigned SB_W  = dds_pkg::DIV_SB_W_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    input  logic [SB_W-1:0]  i_sb,
    output logic             o_valid,
    output logic [NUM_W-1:0] o_quot,
    output logic [SB_W-1:0]  o_sb
);

    logic             r_v   [0:NUM_W-1];
    logic [DEN_W-1:0] r_rem [0:NUM_W-1];
    logic [NUM_W-1:0] r_nq  [0:NUM_W-1];
    logic [SB_W-1:0]  r_sb  [0:NUM_W-1];

    for (genvar k = 0; k < NUM_W; k++) begin : g_stage
        logic             v_in;
        logic [DEN_W-1:0] rem_in;
        logic [NUM_W-1:0] nq_in;
        logic [SB_W-1:0]  sb_in;
        logic [DEN_W:0]   trial;
        logic             take;

        if (k == 0) begin : g_first
            assign v_in   = i_valid;
            assign rem_in = '0;
            assign nq_in  = i_num;
            assign sb_in  = i_sb;
        end else begin : g_next
            assign v_in   = r_v[k-1];
            assign rem_in = r_rem[k-1];
            assign nq_in  = r_nq[k-1];
            assign sb_in  = r_sb[k-1];
        end

        assign trial = {rem_in, nq_in[NUM_W-1]};
        assign take  = (trial >= {1'b0, i_den});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else begin
                r_v[k] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            r_rem[k] <= take ? DEN_W'(trial - {1'b0, i_den}) : trial[DEN_W-1:0];
            r_nq[k]  <= {nq_in[NUM_W-2:0], take};
            r_sb[k]  <= sb_in;
        end
    end

    assign o_valid = r_v[NUM_W-1];
    assign o_quot  = r_nq[NUM_W-1];
    assign o_sb    = r_sb[NUM_W-1];

    `DDS_ASSERT_NXT(a_div_enter, i_valid, r_v[0], "divider dropped an entering transaction")
    `DDS_ASSERT_IMP(a_div_latency, o_valid, $past(i_valid, NUM_W), "divider output without input")

endmodule
